[sv/iff_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package iff_pkg;

    localparam int VALUE_W = 64;
    localparam int FUNC_W  = 2;
    localparam int FW_W    = 6;
    localparam int DIGIT_W = 4;
    localparam int CNT_W   = 7;
    localparam int CHAR_W  = 8;

    localparam logic [FUNC_W-1:0] FUNC_DEC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_OCT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_HEX = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BLANK    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_STAR     = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS     = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS    = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_HEX_BASE = 8'h37;

    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;
    localparam logic [DIGIT_W-1:0] DEC_LIMIT    = 4'd10;

    typedef struct packed {
        logic load;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DEC_LIMIT)
        begin
            return CH_ZERO + ext;
        end
        return CH_HEX_BASE + ext;
    endfunction

endpackage

`default_nettype wire

[sv/integer_field_formatter.sv]
`timescale 1ns / 1ps
`default_nettype none

// Formats one integer per transaction as a right-justified ASCII field in signed
// decimal, octal or hexadecimal, one character per cycle on out_char with strobe,
// and last on the final character. A transaction is taken when start is high and
// busy is low; busy then stays high until the last character has been produced.
// A transaction runs a load step, shift-and-add steps in the digit cell row for
// decimal only, shifts of leading zeros out of the row, a setup step and then
// the field characters (at most MAX_FIELD). Each character appears in the cycle
// after it is produced and is shown for exactly one cycle; the receiver cannot
// stall, so it must take every strobe. The user must write plus_signs through
// cfg_we and cfg_wdata only while the block is idle, which it does not enforce.

module integer_field_formatter #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_FIELD  = 63
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire [iff_pkg::VALUE_W-1:0] value,
    input  wire [iff_pkg::FUNC_W-1:0]  func,
    input  wire [iff_pkg::FW_W-1:0]    field_width,
    input  wire [iff_pkg::FW_W-1:0]    min_digits,
    input  wire                        cfg_we,
    input  wire                        cfg_wdata,
    output logic                       strobe,
    output logic [iff_pkg::CHAR_W-1:0] out_char,
    output logic                       last
);
    import iff_pkg::*;

    localparam int NCELL     = (VALUE_BITS + 2) / 3;
    localparam int SHIFT_W   = $clog2(NCELL);
    localparam int BIT_CNT_W = $clog2(VALUE_BITS);
    localparam int EXT_W     = DIGIT_W * NCELL;

    localparam logic [SHIFT_W-1:0]   SHIFT_END = SHIFT_W'(NCELL - 1);
    localparam logic [BIT_CNT_W-1:0] BIT_LAST  = BIT_CNT_W'(VALUE_BITS - 1);
    localparam logic [CNT_W-1:0]     NCELL_C   = CNT_W'(NCELL);
    localparam logic [CNT_W-1:0]     MAXF_C    = CNT_W'(MAX_FIELD);
    localparam logic [CNT_W-1:0]     MAXD_C    = CNT_W'(MAX_FIELD - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_NORM  = 3'd2;
    localparam logic [2:0] ST_SETUP = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       plus_signs_reg;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [SHIFT_W-1:0]    shift_cnt_reg, shift_cnt_next;
    logic sign_reg, sign_next;
    logic neg_reg, neg_next;
    logic star_reg, star_next;
    logic [CNT_W-1:0] width_reg, width_next;
    logic [CNT_W-1:0] mind_reg, mind_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] th1_reg, th1_next;
    logic [CNT_W-1:0] th2_reg, th2_next;
    logic [CNT_W-1:0] th3_reg, th3_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic strobe_reg, strobe_next;
    logic last_reg, last_next;
    logic [CHAR_W-1:0] char_reg, char_next;

    cell_ctrl_t ctrl;
    logic [DIGIT_W-1:0] load_digits [NCELL];
    logic [DIGIT_W-1:0] digits [NCELL];
    logic               bits_out [NCELL];
    logic [VALUE_BITS-1:0] val;
    logic [EXT_W-1:0]      ext;
    logic                  accept;
    logic                  is_oct, is_hex;
    logic [DIGIT_W-1:0]    top_digit;

    logic [CNT_W-1:0] nd, ndig, need, tot;
    logic             too_small;

    assign val    = value[VALUE_BITS-1:0];
    assign ext    = {{(EXT_W-VALUE_BITS){1'b0}}, val};
    assign accept = start && !busy;
    assign is_oct = (func == FUNC_OCT);
    assign is_hex = (func == FUNC_HEX);
    assign top_digit = digits[NCELL-1];

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            always_comb
            begin
                if (is_oct)
                begin
                    load_digits[gi] = {1'b0, ext[3*gi +: 3]};
                end
                else if (is_hex)
                begin
                    load_digits[gi] = ext[DIGIT_W*gi +: DIGIT_W];
                end
                else
                begin
                    load_digits[gi] = '0;
                end
            end

            if (gi == 0)
            begin : g_first
                iff_digit_cell u_cell (
                    .clk       (clk),
                    .ctrl      (ctrl),
                    .load_digit(load_digits[gi]),
                    .in_bit    (mag_reg[VALUE_BITS-1]),
                    .in_digit  ({DIGIT_W{1'b0}}),
                    .out_bit   (bits_out[gi]),
                    .digit     (digits[gi])
                );
            end
            else
            begin : g_rest
                iff_digit_cell u_cell (
                    .clk       (clk),
                    .ctrl      (ctrl),
                    .load_digit(load_digits[gi]),
                    .in_bit    (bits_out[gi-1]),
                    .in_digit  (digits[gi-1]),
                    .out_bit   (bits_out[gi]),
                    .digit     (digits[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        nd   = NCELL_C - CNT_W'(shift_cnt_reg);
        ndig = (mind_reg > nd) ? mind_reg : nd;
        need = ndig + CNT_W'(sign_reg);
        tot  = (need < width_reg) ? width_reg : need;
        too_small = ((width_reg != '0) && (width_reg < need)) || (tot > MAXF_C);
    end

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_cnt_next = shift_cnt_reg;
        sign_next      = sign_reg;
        neg_next       = neg_reg;
        star_next      = star_reg;
        width_next     = width_reg;
        mind_next      = mind_reg;
        total_next     = total_reg;
        th1_next       = th1_reg;
        th2_next       = th2_reg;
        th3_next       = th3_reg;
        pos_next       = pos_reg;
        strobe_next    = 1'b0;
        last_next      = last_reg;
        char_next      = char_reg;
        ctrl           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load = 1'b1;
                    width_next = (CNT_W'(field_width) > MAXF_C) ? MAXF_C
                                                                 : CNT_W'(field_width);
                    mind_next  = (CNT_W'(min_digits) > MAXD_C) ? MAXD_C
                                                                : CNT_W'(min_digits);
                    shift_cnt_next = '0;
                    if (is_oct || is_hex)
                    begin
                        sign_next  = 1'b0;
                        neg_next   = 1'b0;
                        state_next = ST_NORM;
                    end
                    else
                    begin
                        neg_next     = val[VALUE_BITS-1];
                        sign_next    = val[VALUE_BITS-1] | plus_signs_reg;
                        mag_next     = val[VALUE_BITS-1] ? (~val + 1'b1) : val;
                        bit_cnt_next = BIT_LAST;
                        state_next   = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                ctrl.dabble  = 1'b1;
                mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if ((top_digit != '0) || (shift_cnt_reg == SHIFT_END))
                begin
                    state_next = ST_SETUP;
                end
                else
                begin
                    ctrl.shift     = 1'b1;
                    shift_cnt_next = shift_cnt_reg + 1'b1;
                end
            end
            ST_SETUP:
            begin
                star_next  = too_small;
                total_next = too_small ? ((width_reg != '0) ? width_reg : MAXF_C) : tot;
                th1_next   = tot - need;
                th2_next   = tot - need + CNT_W'(sign_reg);
                th3_next   = tot - nd;
                pos_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                last_next   = (pos_reg == total_reg - 1'b1);
                if (star_reg)
                begin
                    char_next = CH_STAR;
                end
                else if (pos_reg < th1_reg)
                begin
                    char_next = CH_BLANK;
                end
                else if (pos_reg < th2_reg)
                begin
                    char_next = neg_reg ? CH_MINUS : CH_PLUS;
                end
                else if (pos_reg < th3_reg)
                begin
                    char_next = CH_ZERO;
                end
                else
                begin
                    char_next  = digit_char(top_digit);
                    ctrl.shift = 1'b1;
                end
                pos_next = pos_reg + 1'b1;
                if (pos_reg == total_reg - 1'b1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            plus_signs_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            if (cfg_we)
            begin
                plus_signs_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        bit_cnt_reg   <= bit_cnt_next;
        shift_cnt_reg <= shift_cnt_next;
        sign_reg      <= sign_next;
        neg_reg       <= neg_next;
        star_reg      <= star_next;
        width_reg     <= width_next;
        mind_reg      <= mind_next;
        total_reg     <= total_next;
        th1_reg       <= th1_next;
        th2_reg       <= th2_next;
        th3_reg       <= th3_next;
        pos_reg       <= pos_next;
        last_reg      <= last_next;
        char_reg      <= char_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign strobe   = strobe_reg;
    assign out_char = char_reg;
    assign last     = last_reg;

endmodule

`default_nettype wire

[sv/iff_digit_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module iff_digit_cell (
    input  wire                        clk,
    input  iff_pkg::cell_ctrl_t        ctrl,
    input  wire [iff_pkg::DIGIT_W-1:0] load_digit,
    input  wire                        in_bit,
    input  wire [iff_pkg::DIGIT_W-1:0] in_digit,
    output logic                       out_bit,
    output logic [iff_pkg::DIGIT_W-1:0] digit
);
    import iff_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    always_comb
    begin
        adj = (digit_reg >= DABBLE_LIMIT) ? digit_reg + DABBLE_ADD : digit_reg;
        out_bit = adj[DIGIT_W-1];
        digit_next = digit_reg;
        if (ctrl.load)
        begin
            digit_next = load_digit;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[DIGIT_W-2:0], in_bit};
        end
        else if (ctrl.shift)
        begin
            digit_next = in_digit;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

`default_nettype wire

[verif/integer_field_formatter_checker.sv]
`timescale 1ns / 1ps

module integer_field_formatter_checker
    import iff_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    input  wire                busy,
    input  wire [VALUE_W-1:0]  value,
    input  wire [FUNC_W-1:0]   func,
    input  wire [FW_W-1:0]     field_width,
    input  wire [FW_W-1:0]     min_digits,
    input  wire                cfg_we,
    input  wire                cfg_wdata,
    input  wire                strobe,
    input  wire [CHAR_W-1:0]   out_char,
    input  wire                last,
    output int                 fail_count,
    output int                 pending_chars
);

    localparam int MAX_FIELD  = 63;
    localparam int MAX_DIGITS = 24;
    localparam logic [CHAR_W-1:0] CH_LETTER_A = "A";

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } field_char_t;

    field_char_t char_queue[$];
    logic        plus_mode = 1'b0;
    int          mismatches = 0;

    task automatic predict_field(
        input logic [VALUE_W-1:0] v,
        input logic [FUNC_W-1:0]  f,
        input logic [FW_W-1:0]    w,
        input logic [FW_W-1:0]    m
    );
        logic [VALUE_W-1:0] mag;
        logic [CHAR_W-1:0]  digs[MAX_DIGITS];
        logic [DIGIT_W-1:0] d;
        logic               sign;
        logic               neg;
        int                 nd;
        int                 wd;
        int                 md;
        int                 ndigits;
        int                 total;
        int                 pos;
        int                 i;
        wd = w;
        md = (m > MAX_FIELD - 1) ? MAX_FIELD - 1 : m;
        mag = v;
        nd = 0;
        sign = 1'b0;
        neg = 1'b0;
        if (f == FUNC_OCT || f == FUNC_HEX)
        begin
            do
            begin
                d = (f == FUNC_OCT) ? {1'b0, mag[2:0]} : mag[3:0];
                digs[nd] = (d < 4'd10) ? CH_ZERO + CHAR_W'(d)
                                       : CH_LETTER_A + CHAR_W'(d - 4'd10);
                nd++;
                mag = (f == FUNC_OCT) ? mag >> 3 : mag >> 4;
            end
            while (mag != 0);
        end
        else
        begin
            // The undefined radix code falls through to signed decimal.
            sign = plus_mode;
            if (mag[VALUE_W-1])
            begin
                mag = -mag;
                neg = 1'b1;
                sign = 1'b1;
            end
            do
            begin
                digs[nd] = CH_ZERO + CHAR_W'(mag % 10);
                nd++;
                mag = mag / 10;
            end
            while (mag != 0);
        end

        ndigits = (md > nd) ? md : nd;
        total = ndigits + sign;
        if (total < wd)
        begin
            total = wd;
        end

        if ((wd != 0 && wd < total) || total > MAX_FIELD)
        begin
            total = (wd != 0) ? wd : MAX_FIELD;
            for (pos = 0; pos < total; pos++)
            begin
                char_queue.push_back('{ch: CH_STAR, last: pos == total - 1});
            end
            return;
        end

        pos = 0;
        for (i = total - ndigits - sign; i > 0; i--)
        begin
            char_queue.push_back('{ch: CH_BLANK, last: pos == total - 1});
            pos++;
        end
        if (sign)
        begin
            char_queue.push_back('{ch: neg ? CH_MINUS : CH_PLUS, last: pos == total - 1});
            pos++;
        end
        for (i = ndigits - nd; i > 0; i--)
        begin
            char_queue.push_back('{ch: CH_ZERO, last: pos == total - 1});
            pos++;
        end
        for (i = nd - 1; i >= 0; i--)
        begin
            char_queue.push_back('{ch: digs[i], last: pos == total - 1});
            pos++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        field_char_t want;
        if (!rst_n)
        begin
            plus_mode = 1'b0;
            char_queue.delete();
            pending_chars <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            if (cfg_we)
            begin
                plus_mode = cfg_wdata;
            end
            if (strobe)
            begin
                if (char_queue.size() == 0)
                begin
                    $display("%0t: unexpected char %h last %b with no transaction pending",
                             $time, out_char, last);
                    mismatches++;
                end
                else
                begin
                    want = char_queue.pop_front();
                    if (out_char !== want.ch || last !== want.last)
                    begin
                        $display("%0t: char mismatch, expected %h last %b, got %h last %b",
                                 $time, want.ch, want.last, out_char, last);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                predict_field(value, func, field_width, min_digits);
            end
            pending_chars <= char_queue.size();
            fail_count <= mismatches;
        end
    end

endmodule

[verif/integer_field_formatter_tb.sv]
`timescale 1ns / 1ps

module integer_field_formatter_tb;

    import iff_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNDEF = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [VALUE_W-1:0] value;
    logic [FUNC_W-1:0]  func;
    logic [FW_W-1:0]    field_width;
    logic [FW_W-1:0]    min_digits;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               strobe;
    logic [CHAR_W-1:0]  out_char;
    logic               last;
    int                 fail_count;
    int                 pending_chars;
    bit                 steady = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    integer_field_formatter uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .value       (value),
        .func        (func),
        .field_width (field_width),
        .min_digits  (min_digits),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .strobe      (strobe),
        .out_char    (out_char),
        .last        (last)
    );

    integer_field_formatter_checker field_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .value         (value),
        .func          (func),
        .field_width   (field_width),
        .min_digits    (min_digits),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .strobe        (strobe),
        .out_char      (out_char),
        .last          (last),
        .fail_count    (fail_count),
        .pending_chars (pending_chars)
    );

    task automatic send_field(
        input logic [VALUE_W-1:0] v,
        input logic [FUNC_W-1:0]  f,
        input logic [FW_W-1:0]    w,
        input logic [FW_W-1:0]    m
    );
        int gap;
        start       <= 1'b1;
        value       <= v;
        func        <= f;
        field_width <= w;
        min_digits  <= m;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        if (!steady && $urandom_range(0, 99) < 25)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 160)
                                              : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_plus_signs(input logic v);
        start <= 1'b0;
        @(posedge clk);
        while (pending_chars != 0 || busy)
        begin
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_edge_fields();
        send_field(64'd0, FUNC_DEC, 6'd0, 6'd0);
        send_field(64'd0, FUNC_HEX, 6'd0, 6'd0);
        send_field(64'h8000_0000_0000_0000, FUNC_DEC, 6'd0, 6'd0);
        send_field(64'hFFFF_FFFF_FFFF_FFFF, FUNC_DEC, 6'd0, 6'd0);
        send_field(64'hFFFF_FFFF_FFFF_FFFF, FUNC_OCT, 6'd0, 6'd0);
        send_field(64'hFFFF_FFFF_FFFF_FFFF, FUNC_HEX, 6'd63, 6'd0);
        send_field(64'h7FFF_FFFF_FFFF_FFFF, FUNC_DEC, 6'd5, 6'd0);
        send_field(64'd12345, FUNC_UNDEF, 6'd10, 6'd7);
        send_field(64'd255, FUNC_HEX, 6'd6, 6'd63);
        send_field(64'd42, FUNC_DEC, 6'd0, 6'd63);
        send_field(64'd0, FUNC_OCT, 6'd1, 6'd0);
        send_field(64'hDEAD_BEEF, FUNC_HEX, 6'd0, 6'd12);
        send_field(64'd7, FUNC_DEC, 6'd1, 6'd0);
        send_field(-64'sd123, FUNC_DEC, 6'd63, 6'd63);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return VALUE_W'($urandom_range(0, 999));
            2: return -VALUE_W'($urandom_range(1, 999));
            3: return 64'd1 << $urandom_range(0, 63);
            4: return ~(64'd1 << $urandom_range(0, 63));
            default: return {32'hFFFF_FFFF, $urandom};
        endcase
    endfunction

    task automatic send_random_fields(input int count);
        logic [FUNC_W-1:0] f;
        int                r;
        repeat (count)
        begin
            r = $urandom_range(0, 9);
            f = (r < 3) ? FUNC_DEC : (r < 6) ? FUNC_OCT : (r < 9) ? FUNC_HEX : FUNC_UNDEF;
            send_field(pick_value(), f,
                       FW_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                         : $urandom_range(0, 24)),
                       FW_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                         : $urandom_range(0, 22)));
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        value       <= '0;
        func        <= FUNC_DEC;
        field_width <= '0;
        min_digits  <= '0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_plus_signs(1'b0);
        send_edge_fields();
        write_plus_signs(1'b1);
        send_edge_fields();
        send_random_fields(90);
        write_plus_signs(1'b0);
        steady = 1'b1;
        send_random_fields(60);
        steady = 1'b0;
        send_random_fields(40);
        write_plus_signs(1'b1);
        send_random_fields(92);

        start <= 1'b0;
        @(posedge clk);
        while (pending_chars != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending_chars == 0)
        begin
            $display("integer_field_formatter_tb passed");
        end
        else
        begin
            $display("integer_field_formatter_tb failed");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("integer_field_formatter_tb failed");
        $finish;
    end

endmodule

[sim.f]
sv/iff_pkg.sv
sv/iff_digit_cell.sv
sv/integer_field_formatter.sv
verif/integer_field_formatter_checker.sv
verif/integer_field_formatter_tb.sv
